@@ rtl/core/terminal_key_escape_decoder_top_macros.svh @@
// Assertion helpers for the escape decoder.
`ifndef TERMINAL_KEY_ESCAPE_DECODER_TOP_MACROS_SVH
`define TERMINAL_KEY_ESCAPE_DECODER_TOP_MACROS_SVH

// Check a property on every clock outside reset.
`define TKED_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("tked: assertion failed");

// Check that a condition implies another on the next clock.
`define TKED_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tked: sequence check failed");

`endif

@@ rtl/core/tked_pkg.sv @@
`timescale 1ns / 1ps
package tked_pkg;

	localparam int unsigned DEF_PARAM_DEPTH = 16;

	// symbol kinds
	localparam logic [3:0] K_CHAR   = 4'd0;
	localparam logic [3:0] K_CTRL   = 4'd1;
	localparam logic [3:0] K_UP     = 4'd2;
	localparam logic [3:0] K_DOWN   = 4'd3;
	localparam logic [3:0] K_RIGHT  = 4'd4;
	localparam logic [3:0] K_LEFT   = 4'd5;
	localparam logic [3:0] K_HOME   = 4'd6;
	localparam logic [3:0] K_END    = 4'd7;
	localparam logic [3:0] K_INSERT = 4'd8;
	localparam logic [3:0] K_DELETE = 4'd9;
	localparam logic [3:0] K_PGUP   = 4'd10;
	localparam logic [3:0] K_PGDN   = 4'd11;
	localparam logic [3:0] K_REPORT = 4'd12;

	// byte codes
	localparam logic [7:0] CH_ESC    = 8'h1B;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DEL    = 8'h7F;
	localparam logic [7:0] CH_LBRKT  = 8'h5B;
	localparam logic [7:0] CH_TILDE  = 8'h7E;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_TWO    = 8'h32;
	localparam logic [7:0] CH_THREE  = 8'h33;
	localparam logic [7:0] CH_FOUR   = 8'h34;
	localparam logic [7:0] CH_FIVE   = 8'h35;
	localparam logic [7:0] CH_SIX    = 8'h36;
	localparam logic [7:0] CH_SEVEN  = 8'h37;
	localparam logic [7:0] CH_EIGHT  = 8'h38;
	localparam logic [7:0] FIN_UP    = 8'h41;
	localparam logic [7:0] FIN_DOWN  = 8'h42;
	localparam logic [7:0] FIN_RIGHT = 8'h43;
	localparam logic [7:0] FIN_LEFT  = 8'h44;
	localparam logic [7:0] FIN_END   = 8'h46;
	localparam logic [7:0] FIN_FIVE  = 8'h47;
	localparam logic [7:0] FIN_HOME  = 8'h48;
	localparam logic [7:0] FIN_RPT   = 8'h52;
	localparam logic [7:0] FIN_PGUP  = 8'h53;
	localparam logic [7:0] FIN_PGDN  = 8'h54;

	typedef struct packed {
		logic [31:0] col;
		logic [31:0] row;
		logic [7:0]  sym_byte;
		logic [3:0]  kind;
	} sym_t;

endpackage

@@ rtl/core/tked_parser.sv @@
`timescale 1ns / 1ps
module tked_parser
	import tked_pkg::*;
#(
	parameter int unsigned PARAM_DEPTH = DEF_PARAM_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] in_byte,
	output logic       emit,
	output sym_t       sym
);

	localparam int unsigned CW = $clog2(PARAM_DEPTH + 1);

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_ESC   = 4'b0010,
		PH_PARAM = 4'b0100,
		PH_INTER = 4'b1000
	} phase_t;

	typedef enum logic [5:0] {
		RP_ROW0 = 6'b000001,
		RP_ROW  = 6'b000010,
		RP_COL0 = 6'b000100,
		RP_COL  = 6'b001000,
		RP_BAD  = 6'b010000,
		RP_DONE = 6'b100000
	} rphase_t;

	phase_t      phase_q, phase_d;
	rphase_t     rp_q, rp_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [7:0]  first_q, first_d;
	logic [31:0] row_q, row_d;
	logic [31:0] col_q, col_d;

	logic        is_digit;
	logic        is_param;
	logic        is_inter;
	logic [31:0] dval;
	logic [31:0] row_next;
	logic [31:0] col_next;

	assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
	assign is_param = (in_byte >= CH_ZERO) && (in_byte <= CH_QMARK);
	assign is_inter = (in_byte == CH_SPACE) || ((in_byte >= CH_HASH) && (in_byte <= CH_SLASH));
	assign dval     = 32'(in_byte[3:0]);
	assign row_next = {row_q[28:0], 3'b000} + {row_q[30:0], 1'b0} + dval;
	assign col_next = {col_q[28:0], 3'b000} + {col_q[30:0], 1'b0} + dval;

	always_comb begin
		phase_d = phase_q;
		rp_d    = rp_q;
		cnt_d   = cnt_q;
		first_d = first_q;
		row_d   = row_q;
		col_d   = col_q;
		emit    = 1'b0;
		sym     = '0;
		unique case (phase_q) inside
			PH_IDLE: begin
				if (in_byte == CH_ESC) begin
					phase_d = PH_ESC;
				end else begin
					emit         = 1'b1;
					sym.sym_byte = in_byte;
					sym.kind     = ((in_byte < CH_SPACE) || (in_byte == CH_DEL)) ? K_CTRL : K_CHAR;
				end
			end
			PH_ESC: begin
				if (in_byte == CH_LBRKT) begin
					phase_d = PH_PARAM;
					cnt_d   = '0;
					first_d = '0;
					row_d   = '0;
					col_d   = '0;
					rp_d    = RP_ROW0;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_PARAM, PH_INTER: begin
				if ((phase_q == PH_PARAM) && is_param) begin
					if (cnt_q < CW'(PARAM_DEPTH)) begin
						if (cnt_q == '0) begin
							first_d = in_byte;
						end
						cnt_d = cnt_q + CW'(1);
						unique case (rp_q) inside
							RP_ROW0, RP_ROW: begin
								if (is_digit) begin
									row_d = row_next;
									rp_d  = RP_ROW;
								end else if ((rp_q == RP_ROW) && (in_byte == CH_SEMI)) begin
									rp_d = RP_COL0;
								end else begin
									rp_d = RP_BAD;
								end
							end
							RP_COL0, RP_COL: begin
								if (is_digit) begin
									col_d = col_next;
									rp_d  = RP_COL;
								end else begin
									rp_d = (rp_q == RP_COL) ? RP_DONE : RP_BAD;
								end
							end
							default: begin
								rp_d = rp_q;
							end
						endcase
					end
				end else if (is_inter) begin
					phase_d = PH_INTER;
				end else begin
					phase_d = PH_IDLE;
					emit    = 1'b1;
					unique case (in_byte)
						FIN_UP:    sym.kind = K_UP;
						FIN_DOWN:  sym.kind = K_DOWN;
						FIN_RIGHT: sym.kind = K_RIGHT;
						FIN_LEFT:  sym.kind = K_LEFT;
						FIN_END:   sym.kind = K_END;
						FIN_HOME:  sym.kind = K_HOME;
						FIN_PGUP:  sym.kind = K_PGUP;
						FIN_PGDN:  sym.kind = K_PGDN;
						FIN_FIVE: begin
							sym.kind     = K_CHAR;
							sym.sym_byte = CH_FIVE;
						end
						FIN_RPT: begin
							sym.kind = K_REPORT;
							sym.row  = row_q;
							sym.col  = col_q;
							emit     = (rp_q == RP_COL) || (rp_q == RP_DONE);
						end
						CH_TILDE: begin
							unique case (first_q) inside
								CH_ONE, CH_SEVEN:  sym.kind = K_HOME;
								CH_TWO:            sym.kind = K_INSERT;
								CH_THREE:          sym.kind = K_DELETE;
								CH_FOUR, CH_EIGHT: sym.kind = K_END;
								CH_FIVE:           sym.kind = K_PGUP;
								CH_SIX:            sym.kind = K_PGDN;
								default:           emit = 1'b0;
							endcase
							if (cnt_q != CW'(1)) begin
								emit = 1'b0;
							end
						end
						default: begin
							emit = 1'b0;
						end
					endcase
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			rp_q    <= RP_ROW0;
			cnt_q   <= '0;
			first_q <= '0;
			row_q   <= '0;
			col_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			rp_q    <= rp_d;
			cnt_q   <= cnt_d;
			first_q <= first_d;
			row_q   <= row_d;
			col_q   <= col_d;
		end
	end

endmodule

@@ rtl/core/terminal_key_escape_decoder_top.sv @@
`timescale 1ns / 1ps
// An accepted byte is held in the input register, then its key symbol in the output register.
// Throughput: one byte per cycle when not stalled; the state steps once per byte.
// A stalled output register holds its symbol while the input register still fills.
// Reset (arst_n low) clears the parse state, the report numbers and both valid flags.
`include "terminal_key_escape_decoder_top_macros.svh"
module terminal_key_escape_decoder_top
	import tked_pkg::*;
#(
	parameter int unsigned PARAM_DEPTH = DEF_PARAM_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] in_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata   // [3:0] sym_kind, [11:4] sym_byte, [43:12] report_row,
	                              // [75:44] report_col, [79:76] zero
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       emit;
	sym_t       sym;
	logic       out_valid_q;
	sym_t       out_q;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	tked_parser #(
		.PARAM_DEPTH(PARAM_DEPTH)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (valid_s1 && advance),
		.in_byte (byte_s1),
		.emit    (emit),
		.sym     (sym)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			out_q <= sym;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_q};

	`TKED_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready)
	`TKED_ASSERT(a_rose_needs_item, $rose(m_tvalid) |-> $past(valid_s1))
	`TKED_ASSERT_NEXT(a_no_item_no_result, !m_tvalid && !valid_s1, !m_tvalid)
	`TKED_ASSERT(a_report_fields, (m_tvalid && (m_tdata[3:0] != K_REPORT)) |-> (m_tdata[75:12] == '0))

endmodule
